FILE: design/binary_blob_counter_top_macros.svh
// Assertion shorthands for the blob counter checker.
// Both sample on the rising edge of clk and are off while arst_n is low.
`ifndef BINARY_BLOB_COUNTER_TOP_MACROS_SVH
`define BINARY_BLOB_COUNTER_TOP_MACROS_SVH

// Same-cycle implication
`define BBC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bbc check failed");

// Next-cycle implication
`define BBC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bbc check failed");

`endif

FILE: design/bbc_pkg.sv
package bbc_pkg;

	// Default image bounds
	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;

	// Size registers come out of reset at this value (clamped to the bounds)
	localparam int SIZE_RESET = 64;

	// Config port
	localparam int CFG_DW = 7;
	localparam int CFG_IW = 2;

	localparam logic [CFG_IW-1:0] REG_CONN   = 2'd0;
	localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd2;

	// Result width; the tally saturates at all ones
	localparam int COUNT_W = 12;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_POP,
		ST_POP_WAIT,
		ST_NB,
		ST_NB_CHK,
		ST_DONE
	} state_t;

	// One coordinate step toward a neighbor
	typedef enum logic [1:0] {
		STEP_ZERO  = 2'd0,
		STEP_PLUS  = 2'd1,
		STEP_MINUS = 2'd2
	} step_t;

	// Neighbor offsets: four orthogonal first, then the four diagonals
	localparam step_t NB_DR [8] = '{STEP_ZERO, STEP_ZERO, STEP_PLUS, STEP_MINUS,
		STEP_PLUS, STEP_MINUS, STEP_MINUS, STEP_PLUS};
	localparam step_t NB_DC [8] = '{STEP_MINUS, STEP_PLUS, STEP_ZERO, STEP_ZERO,
		STEP_MINUS, STEP_PLUS, STEP_MINUS, STEP_PLUS};

	localparam logic [2:0] NB_LAST4 = 3'd3;
	localparam logic [2:0] NB_LAST8 = 3'd7;

endpackage

FILE: design/binary_blob_counter_top.sv
// Load: one pixel per cycle while busy is low; a pixel without end_of_image completes in its cycle.
// Count: after end_of_image, the scan reads and checks each loaded pixel in use; a foreground
//   pixel starts a blob, whose pixels are popped off a stack and whose neighbors (four or eight)
//   are read unless off image or unloaded, until the stack is empty; the image memory has one read port.
// Reset: arst_n clears the sequencer, counters and config (4-connected, 64 x 64); memories keep data.
// done strobes one cycle at the end, never held (no receiver stall); next image may start after it.
module binary_blob_counter_top import bbc_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               pixel,
	input  logic               end_of_image,
	output logic               done,
	output logic [COUNT_W-1:0] blob_count,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_IW-1:0]  cfg_index,
	input  logic [CFG_DW-1:0]  cfg_data
);

	localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
	localparam int P_BITS = $clog2(CELLS);
	localparam int L_BITS = P_BITS + 1;
	localparam int W_BITS = $clog2(MAX_WIDTH + 1);
	localparam int H_BITS = $clog2(MAX_HEIGHT + 1);
	localparam int C_BITS = $clog2(MAX_WIDTH);
	localparam int R_BITS = $clog2(MAX_HEIGHT);
	localparam int E_BITS = R_BITS + C_BITS;

	// Config
	logic              cfg_wr;
	logic              cfg_conn;
	logic [W_BITS-1:0] cfg_w;
	logic [H_BITS-1:0] cfg_h;
	logic [L_BITS-1:0] cfg_limit;

	// Control state
	state_t             state_q, state_d;
	logic [L_BITS-1:0]  load_pos_q;
	logic [L_BITS-1:0]  stk_ptr_q;
	logic [COUNT_W-1:0] tally_q;

	// Working registers of the count
	logic              conn_q;
	logic [W_BITS-1:0] w_q;
	logic [H_BITS-1:0] h_q;
	logic [L_BITS-1:0] scan_end_q;
	logic [L_BITS-1:0] sp_q;
	logic [R_BITS-1:0] sr_q;
	logic [C_BITS-1:0] sc_q;
	logic [R_BITS-1:0] cr_q;
	logic [C_BITS-1:0] cc_q;
	logic [P_BITS-1:0] cp_q;
	logic [2:0]        nb_q;
	logic [P_BITS-1:0] np_q;
	logic [R_BITS-1:0] nr_q;
	logic [C_BITS-1:0] nc_q;

	// Memories
	logic              img_mem [CELLS];
	logic              img_rd_q;
	logic              img_we, img_wd, img_re;
	logic [P_BITS-1:0] img_wa, img_ra;
	logic [E_BITS-1:0] stk_mem [CELLS];
	logic [E_BITS-1:0] stk_rd_q;
	logic              stk_we, stk_re;
	logic [P_BITS-1:0] stk_wa, stk_ra;
	logic [E_BITS-1:0] stk_wd;

	// Combinational helpers
	logic              accept, load_ok, scan_more, scan_adv, stk_empty;
	logic [L_BITS-1:0] load_next;
	step_t             dr, dc;
	logic              row_ok, col_ok, nb_ok, nb_last;
	logic [R_BITS-1:0] nr;
	logic [C_BITS-1:0] nc;
	logic [P_BITS-1:0] row_off, col_off, np;

	bbc_cfg #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.conn8     (cfg_conn),
		.width_eff (cfg_w),
		.height_eff(cfg_h),
		.limit     (cfg_limit)
	);

	assign cfg_wr = cfg_valid & cfg_ready;

	// Load and scan bookkeeping
	assign accept    = start & ~busy;
	assign load_ok   = load_pos_q < cfg_limit;
	assign load_next = load_ok ? load_pos_q + L_BITS'(1) : load_pos_q;
	assign scan_more = sp_q < scan_end_q;
	assign stk_empty = stk_ptr_q == '0;
	assign scan_adv  = ((state_q == ST_SCAN_CHK) & ~img_rd_q) |
		((state_q == ST_POP) & stk_empty);

	// Neighbor of the popped pixel: bounds, raster address, loaded check
	assign dr      = NB_DR[nb_q];
	assign dc      = NB_DC[nb_q];
	assign nb_last = nb_q == (conn_q ? NB_LAST8 : NB_LAST4);

	always_comb begin
		unique case (dr)
			STEP_ZERO: begin
				row_ok  = 1'b1;
				nr      = cr_q;
				row_off = '0;
			end
			STEP_PLUS: begin
				row_ok  = (H_BITS'(cr_q) + H_BITS'(1)) < h_q;
				nr      = cr_q + R_BITS'(1);
				row_off = P_BITS'(w_q);
			end
			STEP_MINUS: begin
				row_ok  = cr_q != '0;
				nr      = cr_q - R_BITS'(1);
				row_off = P_BITS'(0) - P_BITS'(w_q);
			end
			default: begin
				row_ok  = 1'b0;
				nr      = cr_q;
				row_off = '0;
			end
		endcase
		unique case (dc)
			STEP_ZERO: begin
				col_ok  = 1'b1;
				nc      = cc_q;
				col_off = '0;
			end
			STEP_PLUS: begin
				col_ok  = (W_BITS'(cc_q) + W_BITS'(1)) < w_q;
				nc      = cc_q + C_BITS'(1);
				col_off = P_BITS'(1);
			end
			STEP_MINUS: begin
				col_ok  = cc_q != '0;
				nc      = cc_q - C_BITS'(1);
				col_off = P_BITS'(0) - P_BITS'(1);
			end
			default: begin
				col_ok  = 1'b0;
				nc      = cc_q;
				col_off = '0;
			end
		endcase
	end

	assign np    = cp_q + row_off + col_off;
	assign nb_ok = row_ok & col_ok & ({1'b0, np} < scan_end_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && end_of_image) begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				state_d = scan_more ? ST_SCAN_CHK : ST_DONE;
			end
			ST_SCAN_CHK: begin
				state_d = img_rd_q ? ST_POP : ST_SCAN_RD;
			end
			ST_POP: begin
				state_d = stk_empty ? ST_SCAN_RD : ST_POP_WAIT;
			end
			ST_POP_WAIT: begin
				state_d = ST_NB;
			end
			ST_NB: begin
				if (nb_ok) begin
					state_d = ST_NB_CHK;
				end else if (nb_last) begin
					state_d = ST_POP;
				end
			end
			ST_NB_CHK: begin
				state_d = nb_last ? ST_POP : ST_NB;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs and memory port controls. Every image write falls in a state that issues no
	// image read, and each read is consumed before the next one, so no forwarding is needed.
	always_comb begin
		busy       = state_q != ST_IDLE;
		cfg_ready  = state_q == ST_IDLE;
		done       = state_q == ST_DONE;
		blob_count = tally_q;
		img_we     = 1'b0;
		img_wa     = load_pos_q[P_BITS-1:0];
		img_wd     = pixel;
		img_re     = 1'b0;
		img_ra     = sp_q[P_BITS-1:0];
		stk_we     = 1'b0;
		stk_wa     = stk_ptr_q[P_BITS-1:0];
		stk_wd     = {sr_q, sc_q};
		stk_re     = 1'b0;
		stk_ra     = stk_ptr_q[P_BITS-1:0] - P_BITS'(1);
		unique case (state_q)
			ST_IDLE: begin
				img_we = start & load_ok;
			end
			ST_SCAN_RD: begin
				img_re = scan_more;
			end
			ST_SCAN_CHK: begin
				img_we = img_rd_q;
				img_wa = sp_q[P_BITS-1:0];
				img_wd = 1'b0;
				stk_we = img_rd_q;
			end
			ST_POP: begin
				stk_re = ~stk_empty;
			end
			ST_NB: begin
				img_re = nb_ok;
				img_ra = np;
			end
			ST_NB_CHK: begin
				img_we = img_rd_q;
				img_wa = np_q;
				img_wd = 1'b0;
				stk_we = img_rd_q;
				stk_wd = {nr_q, nc_q};
			end
			ST_POP_WAIT, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Image and stack memories, registered read
	always_ff @(posedge clk) begin
		if (img_we) begin
			img_mem[img_wa] <= img_wd;
		end
		if (img_re) begin
			img_rd_q <= img_mem[img_ra];
		end
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		if (stk_re) begin
			stk_rd_q <= stk_mem[stk_ra];
		end
	end

	// Sequencer, load position, stack pointer, tally
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			load_pos_q <= '0;
			stk_ptr_q  <= '0;
			tally_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (end_of_image) begin
					load_pos_q <= '0;
					tally_q    <= '0;
				end else if (load_ok) begin
					load_pos_q <= load_pos_q + L_BITS'(1);
				end
			end
			// new blob: count it, seed the stack
			if (state_q == ST_SCAN_CHK && img_rd_q) begin
				if (tally_q != '1) begin
					tally_q <= tally_q + COUNT_W'(1);
				end
				stk_ptr_q <= stk_ptr_q + L_BITS'(1);
			end
			if (stk_re) begin
				stk_ptr_q <= stk_ptr_q - L_BITS'(1);
			end
			if (state_q == ST_NB_CHK && img_rd_q) begin
				stk_ptr_q <= stk_ptr_q + L_BITS'(1);
			end
		end
	end

	// Scan position, popped pixel, neighbor under test
	always_ff @(posedge clk) begin
		if (accept && end_of_image) begin
			conn_q     <= cfg_conn;
			w_q        <= cfg_w;
			h_q        <= cfg_h;
			scan_end_q <= (load_next < cfg_limit) ? load_next : cfg_limit;
			sp_q       <= '0;
			sr_q       <= '0;
			sc_q       <= '0;
		end
		if (scan_adv) begin
			sp_q <= sp_q + L_BITS'(1);
			if ((W_BITS'(sc_q) + W_BITS'(1)) == w_q) begin
				sc_q <= '0;
				sr_q <= sr_q + R_BITS'(1);
			end else begin
				sc_q <= sc_q + C_BITS'(1);
			end
		end
		if (state_q == ST_POP_WAIT) begin
			cr_q <= stk_rd_q[E_BITS-1:C_BITS];
			cc_q <= stk_rd_q[C_BITS-1:0];
			cp_q <= P_BITS'(L_BITS'(stk_rd_q[E_BITS-1:C_BITS]) * L_BITS'(w_q) +
				L_BITS'(stk_rd_q[C_BITS-1:0]));
			nb_q <= '0;
		end
		if (state_q == ST_NB) begin
			if (nb_ok) begin
				np_q <= np;
				nr_q <= nr;
				nc_q <= nc;
			end else if (!nb_last) begin
				nb_q <= nb_q + 3'd1;
			end
		end
		if (state_q == ST_NB_CHK && !nb_last) begin
			nb_q <= nb_q + 3'd1;
		end
	end

endmodule

FILE: design/bbc_cfg.sv
module bbc_cfg import bbc_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	localparam int W_BITS = $clog2(MAX_WIDTH + 1),
	localparam int H_BITS = $clog2(MAX_HEIGHT + 1),
	localparam int L_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	output logic              conn8,
	output logic [W_BITS-1:0] width_eff,
	output logic [H_BITS-1:0] height_eff,
	output logic [L_BITS-1:0] limit
);

	localparam int W_RST = (SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : SIZE_RESET;
	localparam int H_RST = (SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : SIZE_RESET;

	logic              conn_q;
	logic [W_BITS-1:0] w_q;
	logic [H_BITS-1:0] h_q;
	logic [L_BITS-1:0] limit_q;
	logic [W_BITS-1:0] w_new;
	logic [H_BITS-1:0] h_new;

	// Zero reads as one, oversize saturates to the bound
	function automatic logic [W_BITS-1:0] clamp_w(logic [CFG_DW-1:0] d);
		logic [W_BITS-1:0] r;
		if (d == '0) begin
			r = W_BITS'(1);
		end else if (32'(d) > MAX_WIDTH) begin
			r = W_BITS'(MAX_WIDTH);
		end else begin
			r = W_BITS'(d);
		end
		return r;
	endfunction

	function automatic logic [H_BITS-1:0] clamp_h(logic [CFG_DW-1:0] d);
		logic [H_BITS-1:0] r;
		if (d == '0) begin
			r = H_BITS'(1);
		end else if (32'(d) > MAX_HEIGHT) begin
			r = H_BITS'(MAX_HEIGHT);
		end else begin
			r = H_BITS'(d);
		end
		return r;
	endfunction

	assign w_new = clamp_w(cfg_data);
	assign h_new = clamp_h(cfg_data);

	// Register file; the pixel limit is kept as a product so loading needs no multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conn_q  <= 1'b0;
			w_q     <= W_BITS'(W_RST);
			h_q     <= H_BITS'(H_RST);
			limit_q <= L_BITS'(W_RST * H_RST);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_CONN: begin
					conn_q <= cfg_data[0];
				end
				REG_WIDTH: begin
					w_q     <= w_new;
					limit_q <= L_BITS'(L_BITS'(w_new) * L_BITS'(h_q));
				end
				REG_HEIGHT: begin
					h_q     <= h_new;
					limit_q <= L_BITS'(L_BITS'(w_q) * L_BITS'(h_new));
				end
				default: begin
				end
			endcase
		end
	end

	assign conn8      = conn_q;
	assign width_eff  = w_q;
	assign height_eff = h_q;
	assign limit      = limit_q;

endmodule

FILE: design/bbc_checker.sv
`include "binary_blob_counter_top_macros.svh"

module bbc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic end_of_image,
	input logic busy,
	input logic done
);

	// result only comes out of a count in progress
	`BBC_ASSERT_IMP(a_done_in_count, done, busy)

	// the block is free again right after the result beat
	`BBC_ASSERT_NXT(a_free_after_done, done, !busy)

	// a plain pixel never starts a count
	`BBC_ASSERT_NXT(a_pixel_stays_free, start && !busy && !end_of_image, !busy && !done)

	// a count starts only from an end-of-image beat
	`BBC_ASSERT_IMP(a_count_cause, $rose(busy), $past(start && end_of_image))

endmodule

bind binary_blob_counter_top bbc_checker u_bbc_checker (.*);
